FILE: design/mwsl_pkg.sv
// Shared constants and types for the mecanum wheel speed limiter.
package mwsl_pkg;

    localparam int LIMIT_WIDTH     = 15;
    localparam int WHEEL_COUNT     = 4;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: design/mwsl_if.sv
// Command and wheel-speed channel interfaces with valid/ready handshake.
interface mwsl_cmd_if #(parameter int SPEED_WIDTH = 16);
    logic                                valid;
    logic                                ready;
    logic signed [SPEED_WIDTH-1:0]       forward_speed;
    logic signed [SPEED_WIDTH-1:0]       sideways_speed;
    logic signed [SPEED_WIDTH-1:0]       turn_speed;
    logic [mwsl_pkg::LIMIT_WIDTH-1:0]    rpm_limit;

    modport source (
        output valid, forward_speed, sideways_speed, turn_speed, rpm_limit,
        input  ready
    );
    modport sink (
        input  valid, forward_speed, sideways_speed, turn_speed, rpm_limit,
        output ready
    );
endinterface

interface mwsl_wheel_if #(parameter int SPEED_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SPEED_WIDTH-1:0] wheel_front_left;
    logic signed [SPEED_WIDTH-1:0] wheel_front_right;
    logic signed [SPEED_WIDTH-1:0] wheel_back_left;
    logic signed [SPEED_WIDTH-1:0] wheel_back_right;
    logic                          was_scaled;

    modport source (
        output valid, wheel_front_left, wheel_front_right, wheel_back_left,
               wheel_back_right, was_scaled,
        input  ready
    );
    modport sink (
        input  valid, wheel_front_left, wheel_front_right, wheel_back_left,
               wheel_back_right, was_scaled,
        output ready
    );
endinterface

FILE: design/mwsl_front.sv
// Front end: accept commands, form wheel sums and magnitudes, find the peak.
module mwsl_front #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    mwsl_cmd_if.sink                cmd,
    input  mwsl_pkg::queue_status_t qstat,
    output logic                    push,
    output logic [4 + 5*(SPEED_WIDTH+1) + mwsl_pkg::LIMIT_WIDTH:0] entry
);

    localparam int W  = SPEED_WIDTH;
    localparam int SW = W + 2;
    localparam int MW = W + 1;
    localparam int LW = mwsl_pkg::LIMIT_WIDTH;
    localparam logic [32:0] OUT_MAX = (33'd1 << (W - 1)) - 33'd1;

    logic signed [SW-1:0] vx;
    logic signed [SW-1:0] vy;
    logic signed [SW-1:0] vw;
    logic signed [SW-1:0] sum_next [4];
    logic signed [SW-1:0] sum_reg  [4];
    logic [LW-1:0]        lim_next;
    logic [LW-1:0]        lim_reg;
    logic                 a_valid_reg;

    logic [MW-1:0]        mag_next [4];
    logic [MW-1:0]        mag_reg  [4];
    logic [3:0]           neg_next;
    logic [3:0]           neg_reg;
    logic [LW-1:0]        blim_reg;
    logic                 b_valid_reg;

    logic                 adv_a;
    logic                 adv_b;
    logic [MW-1:0]        peak01;
    logic [MW-1:0]        peak23;
    logic [MW-1:0]        peak;
    logic                 scaled;

    assign adv_b     = !b_valid_reg || !qstat.full;
    assign adv_a     = !a_valid_reg || adv_b;
    assign cmd.ready = adv_a;
    assign push      = b_valid_reg && !qstat.full;

    assign vx = SW'(cmd.forward_speed);
    assign vy = SW'(cmd.sideways_speed);
    assign vw = SW'(cmd.turn_speed);

    always_comb
    begin
        sum_next[0] = vx + vy - vw;
        sum_next[1] = vy - vx - vw;
        sum_next[2] = vx - vy - vw;
        sum_next[3] = -vx - vy - vw;
        // clamp the limit to what the output field can hold
        if (33'(cmd.rpm_limit) > OUT_MAX)
            lim_next = LW'(OUT_MAX);
        else
            lim_next = cmd.rpm_limit;
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            neg_next[k] = sum_reg[k][SW-1];
            mag_next[k] = neg_next[k] ? MW'(-sum_reg[k]) : MW'(sum_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                a_valid_reg <= cmd.valid;
            if (adv_b)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            sum_reg <= sum_next;
            lim_reg <= lim_next;
        end
        if (adv_b)
        begin
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            blim_reg <= lim_reg;
        end
    end

    assign peak01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
    assign peak23 = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
    assign peak   = (peak01 > peak23) ? peak01 : peak23;
    // the clamped limit always fits MW bits, so the resize is exact
    assign scaled = peak > MW'(blim_reg);

    assign entry = {scaled, peak, blim_reg,
                    mag_reg[3], mag_reg[2], mag_reg[1], mag_reg[0], neg_reg};

endmodule

FILE: design/mwsl_queue.sv
// Small register queue between the front end and the scaling back end.
module mwsl_queue #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [DATA_WIDTH-1:0]   push_data,
    input  logic                    pop,
    output logic [DATA_WIDTH-1:0]   head_data,
    output mwsl_pkg::queue_status_t status
);

    localparam int PW = mwsl_pkg::QUEUE_PTR_WIDTH;
    localparam int CW = PW + 1;

    logic [DATA_WIDTH-1:0] mem_reg [mwsl_pkg::QUEUE_DEPTH];
    logic [PW-1:0]         wr_ptr_reg;
    logic [PW-1:0]         wr_ptr_next;
    logic [PW-1:0]         rd_ptr_reg;
    logic [PW-1:0]         rd_ptr_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    assign status.full  = count_reg == CW'(mwsl_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: design/mwsl_back.sv
// Back end: multiply by the limit, divide by the peak one bit per stage, restore signs.
module mwsl_back #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [4 + 5*(SPEED_WIDTH+1) + mwsl_pkg::LIMIT_WIDTH:0] entry,
    input  mwsl_pkg::queue_status_t qstat,
    output logic                    pop,
    mwsl_wheel_if.source            wheel
);

    localparam int W  = SPEED_WIDTH;
    localparam int MW = W + 1;
    localparam int LW = mwsl_pkg::LIMIT_WIDTH;
    localparam int PW = MW + LW;
    localparam int EW = 4 + 5*MW + LW + 1;

    logic [MW-1:0] e_mag [4];
    logic [3:0]    e_neg;
    logic [LW-1:0] e_lim;
    logic [MW-1:0] e_peak;
    logic          e_scaled;

    logic          adv;

    logic          v_reg   [0:LW];
    logic [PW-1:0] rem_reg [0:LW][4];
    logic [LW-1:0] quo_reg [0:LW][4];
    logic [3:0]    neg_reg [0:LW];
    logic [MW-1:0] div_reg [0:LW];
    logic          sc_reg  [0:LW];

    logic [PW-1:0] rem0_next [4];
    logic [LW-1:0] quo0_next [4];
    logic [MW-1:0] div0_next;

    logic          out_valid_reg;
    logic [W-1:0]  wheel_reg  [4];
    logic [W-1:0]  wheel_next [4];
    logic          scaled_reg;

    assign adv = !out_valid_reg || wheel.ready;
    assign pop = adv && !qstat.empty;

    always_comb
    begin
        e_neg    = entry[3:0];
        for (int k = 0; k < 4; k++)
            e_mag[k] = entry[4 + k*MW +: MW];
        e_lim    = entry[4 + 4*MW +: LW];
        e_peak   = entry[4 + 4*MW + LW +: MW];
        e_scaled = entry[EW-1];
    end

    // an unscaled wheel already fits the quotient field; a unit divisor keeps it
    always_comb
    begin
        div0_next = e_scaled ? e_peak : MW'(1);
        for (int k = 0; k < 4; k++)
        begin
            rem0_next[k] = e_scaled ? e_mag[k] * e_lim : '0;
            quo0_next[k] = e_scaled ? '0 : LW'(e_mag[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem0_next;
            quo_reg[0] <= quo0_next;
            neg_reg[0] <= e_neg;
            div_reg[0] <= div0_next;
            sc_reg[0]  <= e_scaled;
        end
    end

    for (genvar s = 1; s <= LW; s++)
    begin : g_div
        localparam int BIT = LW - s;

        logic [PW-1:0] trial;
        logic [3:0]    ge;
        logic [PW-1:0] rem_next [4];
        logic [LW-1:0] quo_next [4];

        assign trial = PW'(div_reg[s-1]) << BIT;

        always_comb
        begin
            for (int k = 0; k < 4; k++)
            begin
                ge[k]            = rem_reg[s-1][k] >= trial;
                rem_next[k]      = ge[k] ? rem_reg[s-1][k] - trial : rem_reg[s-1][k];
                quo_next[k]      = quo_reg[s-1][k];
                quo_next[k][BIT] = quo_reg[s-1][k][BIT] | ge[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (adv)
                v_reg[s] <= v_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= rem_next;
                quo_reg[s] <= quo_next;
                neg_reg[s] <= neg_reg[s-1];
                div_reg[s] <= div_reg[s-1];
                sc_reg[s]  <= sc_reg[s-1];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (neg_reg[LW][k])
                wheel_next[k] = W'(-PW'(quo_reg[LW][k]));
            else
                wheel_next[k] = W'(PW'(quo_reg[LW][k]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[LW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wheel_reg  <= wheel_next;
            scaled_reg <= sc_reg[LW];
        end
    end

    assign wheel.valid             = out_valid_reg;
    assign wheel.wheel_front_left  = wheel_reg[0];
    assign wheel.wheel_front_right = wheel_reg[1];
    assign wheel.wheel_back_left   = wheel_reg[2];
    assign wheel.wheel_back_right  = wheel_reg[3];
    assign wheel.was_scaled        = scaled_reg;

endmodule

FILE: design/mecanum_wheel_speed_limiter_unit.sv
// Top level of the mecanum wheel speed limiter.
// Takes one chassis command per clock, unless back-pressure fills the queue, and
// returns the four mecanum wheel speeds, each scaled by limit/peak (truncated
// toward zero) when the largest wheel magnitude exceeds the limit; was_scaled
// marks that case. Sustained rate is one command per cycle without back-pressure.
// The path: two front stages form the sums and magnitudes, a four-entry queue
// follows, then one multiply stage, one restoring-division stage per quotient
// bit (15) and an output register. Stalls on the output hold the back end only;
// the front keeps taking commands until the queue fills.
module mecanum_wheel_speed_limiter_unit #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mwsl_cmd_if.sink      cmd,
    mwsl_wheel_if.source  wheel
);

    localparam int EW = 4 + 5*(SPEED_WIDTH + 1) + mwsl_pkg::LIMIT_WIDTH + 1;

    logic                    push;
    logic                    pop;
    logic [EW-1:0]           front_entry;
    logic [EW-1:0]           head_entry;
    mwsl_pkg::queue_status_t qstat;

    mwsl_front #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .qstat (qstat),
        .push  (push),
        .entry (front_entry)
    );

    mwsl_queue #(
        .DATA_WIDTH (EW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_entry),
        .pop       (pop),
        .head_data (head_entry),
        .status    (qstat)
    );

    mwsl_back #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .entry (head_entry),
        .qstat (qstat),
        .pop   (pop),
        .wheel (wheel)
    );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the mecanum wheel speed limiter unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_WIDTH   = mwsl_pkg::LIMIT_WIDTH;
    localparam int WHEEL_COUNT   = mwsl_pkg::WHEEL_COUNT;

    localparam int SW            = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_OFF_LEN  = 250;

    localparam int WHEEL_FL = 0;
    localparam int WHEEL_FR = 1;
    localparam int WHEEL_BL = 2;
    localparam int WHEEL_BR = 3;

    localparam logic signed [SW-1:0] MAX_SPEED = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_SPEED = {1'b1, {(SW-1){1'b0}}};
    localparam longint               OUT_MAX   = (longint'(1) << (SW-1)) - 1;
    localparam logic [LIMIT_WIDTH-1:0] FULL_LIMIT = '1;

    typedef struct {
        logic signed [SW-1:0]   forward;
        logic signed [SW-1:0]   sideways;
        logic signed [SW-1:0]   turn;
        logic [LIMIT_WIDTH-1:0] limit;
    } chassis_cmd_t;

    typedef struct {
        logic signed [SW-1:0] front_left;
        logic signed [SW-1:0] front_right;
        logic signed [SW-1:0] back_left;
        logic signed [SW-1:0] back_right;
        logic                 scaled;
    } wheel_speeds_t;

    logic clk;
    logic rst_n;

    mwsl_cmd_if   #(.SPEED_WIDTH(SW)) cmd_bus ();
    mwsl_wheel_if #(.SPEED_WIDTH(SW)) wheel_bus ();

    mecanum_wheel_speed_limiter_unit #(
        .SPEED_WIDTH(SW)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .wheel (wheel_bus)
    );

    wheel_speeds_t expected_wheels[$];
    int            mismatch_count;
    int            cycle_count;
    bit            sender_idles;
    bit            receiver_idles;
    int            hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Wheel speed predictor
    // ---------------------------------------------------------------
    function automatic longint wheel_sum(chassis_cmd_t c, int idx);
        longint vx;
        longint vy;
        longint vw;
        vx = c.forward;
        vy = c.sideways;
        vw = c.turn;
        case (idx)
            WHEEL_FL: return vx + vy - vw;
            WHEEL_FR: return -(vx - vy + vw);
            WHEEL_BL: return vx - vy - vw;
            default:  return -(vx + vy + vw);
        endcase
    endfunction

    function automatic longint wheel_peak(chassis_cmd_t c);
        longint peak;
        longint w;
        int     i;
        peak = 0;
        for (i = 0; i < WHEEL_COUNT; i++)
        begin
            w = wheel_sum(c, i);
            if (w < 0)
                w = -w;
            if (w > peak)
                peak = w;
        end
        return peak;
    endfunction

    function automatic wheel_speeds_t limit_wheel_speeds(chassis_cmd_t c);
        wheel_speeds_t r;
        longint        lim;
        longint        peak;
        longint        w;
        longint        q;
        longint        speed[WHEEL_COUNT];
        int            i;
        lim = c.limit;
        if (lim > OUT_MAX)
            lim = OUT_MAX;
        peak = wheel_peak(c);
        r.scaled = (peak > lim);
        for (i = 0; i < WHEEL_COUNT; i++)
        begin
            w = wheel_sum(c, i);
            if (r.scaled)
            begin
                // Scale the magnitude, truncate toward zero, restore the sign.
                q = ((w < 0 ? -w : w) * lim) / peak;
                w = (w < 0) ? -q : q;
            end
            speed[i] = w;
        end
        r.front_left  = speed[WHEEL_FL][SW-1:0];
        r.front_right = speed[WHEEL_FR][SW-1:0];
        r.back_left   = speed[WHEEL_BL][SW-1:0];
        r.back_right  = speed[WHEEL_BR][SW-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic chassis_cmd_t make_cmd(int f, int s, int t, int l);
        chassis_cmd_t c;
        c.forward  = f[SW-1:0];
        c.sideways = s[SW-1:0];
        c.turn     = t[SW-1:0];
        c.limit    = l[LIMIT_WIDTH-1:0];
        return c;
    endfunction

    function automatic logic signed [SW-1:0] random_speed();
        int v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 5))
                    0:       return MIN_SPEED;
                    1:       return MIN_SPEED + SW'(1);
                    2:       return MAX_SPEED;
                    3:       return MAX_SPEED - SW'(1);
                    4:       return '1;
                    default: return '0;
                endcase
            end
            1:
            begin
                v = $urandom_range(0, 64);
                v = v - 32;
                return v[SW-1:0];
            end
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic chassis_cmd_t random_command();
        chassis_cmd_t c;
        longint       near;
        int           off;
        c.forward  = random_speed();
        c.sideways = random_speed();
        c.turn     = random_speed();
        case ($urandom_range(0, 5))
            0: c.limit = '0;
            1: c.limit = FULL_LIMIT;
            2, 3: c.limit = LIMIT_WIDTH'($urandom);
            4: c.limit = LIMIT_WIDTH'($urandom_range(0, 255));
            default:
            begin
                // Land right around the peak so the scale boundary gets hit.
                off  = $urandom_range(0, 4);
                near = wheel_peak(c) + off - 2;
                if (near < 0)
                    near = 0;
                c.limit = (near > OUT_MAX) ? FULL_LIMIT : near[LIMIT_WIDTH-1:0];
            end
        endcase
        return c;
    endfunction

    task automatic send_command(input chassis_cmd_t c);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.forward_speed  <= c.forward;
        cmd_bus.sideways_speed <= c.sideways;
        cmd_bus.turn_speed     <= c.turn;
        cmd_bus.rpm_limit      <= c.limit;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        expected_wheels.push_back(limit_wheel_speeds(c));
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [SW-1:0] got,
                               input logic signed [SW-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // ---------------------------------------------------------------
    // Receiver side: ready driver and result checker
    // ---------------------------------------------------------------
    initial
    begin : wheel_ready_driver
        int stall_left;
        stall_left = 0;
        wheel_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else if (stall_left == 0 && receiver_idles && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                wheel_bus.ready <= 1'b0;
                stall_left--;
            end
            else
                wheel_bus.ready <= rst_n;
        end
    end

    initial
    begin : result_checker
        wheel_speeds_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && wheel_bus.valid && wheel_bus.ready)
            begin
                if (expected_wheels.size() == 0)
                    report_mismatch("wheel result with no request pending");
                else
                begin
                    want = expected_wheels.pop_front();
                    check_field("front_left", wheel_bus.wheel_front_left, want.front_left);
                    check_field("front_right", wheel_bus.wheel_front_right,
                                want.front_right);
                    check_field("back_left", wheel_bus.wheel_back_left, want.back_left);
                    check_field("back_right", wheel_bus.wheel_back_right, want.back_right);
                    check_field("was_scaled", SW'(wheel_bus.was_scaled), SW'(want.scaled));
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_directed_corners();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        // Zero limit: all-zero command stays unscaled, anything else goes to zero.
        send_command(make_cmd(0, 0, 0, 0));
        send_command(make_cmd(100, 0, 0, 0));
        send_command(make_cmd(1, 0, 0, 0));
        send_command(make_cmd(0, 0, -1, 0));
        // Full-range sums.
        send_command(make_cmd(int'(MAX_SPEED), int'(MAX_SPEED), int'(MAX_SPEED),
                              int'(FULL_LIMIT)));
        send_command(make_cmd(int'(MIN_SPEED), int'(MIN_SPEED), int'(MIN_SPEED),
                              int'(FULL_LIMIT)));
        send_command(make_cmd(int'(MIN_SPEED), int'(MIN_SPEED), int'(MAX_SPEED),
                              int'(FULL_LIMIT)));
        send_command(make_cmd(int'(MAX_SPEED), int'(MAX_SPEED), int'(MIN_SPEED),
                              int'(FULL_LIMIT)));
        send_command(make_cmd(int'(MIN_SPEED), int'(MAX_SPEED), int'(MIN_SPEED), 0));
        send_command(make_cmd(int'(MIN_SPEED), int'(MAX_SPEED), 0, int'(FULL_LIMIT)));
        send_command(make_cmd(int'(MIN_SPEED), 0, 0, int'(FULL_LIMIT)));
        send_command(make_cmd(int'(MAX_SPEED), 0, 0, 1));
        // Pure motions, under the limit.
        send_command(make_cmd(500, 0, 0, 1000));
        send_command(make_cmd(0, 500, 0, 1000));
        send_command(make_cmd(0, 0, 500, 1000));
        // Peak equal to the limit stays unscaled, one below scales.
        send_command(make_cmd(300, 200, 100, 600));
        send_command(make_cmd(300, 200, 100, 599));
        // Truncation toward zero on negative wheels.
        send_command(make_cmd(-7, 3, 2, 5));
        send_command(make_cmd(-1, -1, -1, int'(FULL_LIMIT)));
        send_command(make_cmd(12345, -23456, 7890, 'h5555));
        send_command(make_cmd('h5555, 'hAAAA, 'h0F0F, 'h2AAA));
        send_command(make_cmd('hAAAA, 'h5555, 'hF0F0, 'h5555));
    endtask

    task automatic test_full_rate_stream(input int count);
        int i;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        for (i = 0; i < count; i++)
            send_command(random_command());
    endtask

    task automatic test_random_idling(input int count);
        int i;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (i = 0; i < count; i++)
            send_command(random_command());
    endtask

    task automatic test_output_hold_off(input int count);
        int i;
        sender_idles    = 1'b0;
        receiver_idles  = 1'b0;
        // Hold the output long enough for the queue to fill and stall the input.
        hold_off_cycles = HOLD_OFF_LEN;
        for (i = 0; i < count; i++)
            send_command(random_command());
    endtask

    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        while (expected_wheels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : main_sequence
        mismatch_count  = 0;
        hold_off_cycles = 0;
        sender_idles    = 1'b0;
        receiver_idles  = 1'b0;
        rst_n                  <= 1'b0;
        cmd_bus.valid          <= 1'b0;
        cmd_bus.forward_speed  <= '0;
        cmd_bus.sideways_speed <= '0;
        cmd_bus.turn_speed     <= '0;
        cmd_bus.rpm_limit      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_full_rate_stream(150);
        test_random_idling(250);
        test_output_hold_off(60);
        test_random_idling(170);
        drain_results();

        if (mismatch_count == 0 && expected_wheels.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
